// File: rtl/core/v3a_pkg.sv
package v3a_pkg;

  // Fixed-point format of every vector and scalar value.
  localparam int unsigned FRAC_BITS = 16;

  // Multiplier operands are one bit wider than a value so that a - b and 1 - t fit.
  localparam int unsigned OP_W   = 33;
  localparam int unsigned PROD_W = 2 * OP_W;
  localparam int unsigned SUM_W  = PROD_W + 2;

  // Square root: 64-bit radicand, one result bit per stage, one extra bit for rounding.
  localparam int unsigned RAD_W      = 64;
  localparam int unsigned ROOT_STEPS = RAD_W / 2;
  localparam int unsigned ROOT_W     = ROOT_STEPS + 1;

  // Divider: divisor up to the rounded root, 33 quotient bits, rounded numerator.
  localparam int unsigned DIV_W    = ROOT_W;
  localparam int unsigned QUO_BITS = 33;
  localparam int unsigned NUM_W    = 33 + FRAC_BITS;

  typedef logic signed [31:0] q_t;
  typedef logic [3:0]         kind_t;

  localparam kind_t KIND_ADD   = 4'd0;
  localparam kind_t KIND_SUB   = 4'd1;
  localparam kind_t KIND_SCALE = 4'd2;
  localparam kind_t KIND_DIV   = 4'd3;
  localparam kind_t KIND_NEG   = 4'd4;
  localparam kind_t KIND_DOT   = 4'd5;
  localparam kind_t KIND_CROSS = 4'd6;
  localparam kind_t KIND_LEN   = 4'd7;
  localparam kind_t KIND_DIST  = 4'd8;
  localparam kind_t KIND_NORM  = 4'd9;
  localparam kind_t KIND_MIX   = 4'd10;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_ERR = 2'd2;

  localparam q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN = 32'sh8000_0000;

  // Everything an operation carries down the pipeline besides its arithmetic lanes.
  typedef struct packed {
    kind_t    kind;
    q_t [2:0] r;
    q_t       sc;
    logic     sat;
    logic     err;
    q_t [2:0] a;
    q_t       s;
  } side_t;

  typedef struct packed {
    q_t [2:0]   r;
    q_t         sc;
    logic [1:0] status;
  } res_t;

  function automatic logic ovf33(input logic signed [32:0] v);
    return v[32] != v[31];
  endfunction

  function automatic q_t sat33(input logic signed [32:0] v);
    q_t o;
    if (v[32] != v[31]) begin
      o = v[32] ? Q_MIN : Q_MAX;
    end else begin
      o = v[31:0];
    end
    return o;
  endfunction

endpackage

// File: rtl/core/v3a_front.sv
module v3a_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  v3a_pkg::kind_t            kind,
  input  v3a_pkg::q_t               a_x,
  input  v3a_pkg::q_t               a_y,
  input  v3a_pkg::q_t               a_z,
  input  v3a_pkg::q_t               b_x,
  input  v3a_pkg::q_t               b_y,
  input  v3a_pkg::q_t               b_z,
  input  v3a_pkg::q_t               scalar_in,
  output logic                      out_valid,
  output v3a_pkg::side_t            out_side,
  output logic [v3a_pkg::RAD_W-1:0] rad
);
  import v3a_pkg::*;

  typedef logic signed [OP_W-1:0]   op_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam op_t  ONE_OP   = op_t'(1) << FRAC_BITS;
  localparam sum_t HALF_SUM = sum_t'(1) << (FRAC_BITS - 1);
  localparam sum_t SUM_MAX  = sum_t'(Q_MAX);
  localparam sum_t SUM_MIN  = sum_t'(Q_MIN);

  logic v1, v2, v3, v4;
  side_t sd1, sd2, sd3, sd4;
  side_t sd2_next, sd5_next;
  q_t [2:0] b1;

  op_t sa [3];
  op_t sb [3];
  op_t addv [3];
  op_t subv [3];
  op_t negv [3];
  op_t ss, wt;
  op_t opx_next [6];
  op_t opy_next [6];
  op_t opx [6];
  op_t opy [6];
  prod_t prod [6];
  sum_t sum_next [3];
  sum_t sum [3];
  sum_t rnd [3];
  logic [2:0] lane_ovf;
  q_t lane_val [3];
  logic [RAD_W-1:0] rad_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd1.kind <= kind;
      sd1.r    <= '0;
      sd1.sc   <= '0;
      sd1.sat  <= 1'b0;
      sd1.err  <= (kind == KIND_DIV) && (scalar_in == '0);
      sd1.a    <= {a_z, a_y, a_x};
      sd1.s    <= scalar_in;
      b1       <= {b_z, b_y, b_x};
      sd2      <= sd2_next;
      opx      <= opx_next;
      opy      <= opy_next;
      sd3      <= sd2;
      for (int j = 0; j < 6; j++) begin
        prod[j] <= opx[j] * opy[j];
      end
      sd4      <= sd3;
      sum      <= sum_next;
      out_side <= sd5_next;
      rad      <= rad_next;
    end
  end

  // Stage 2: element-wise results and multiplier operand selection.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sa[i]   = op_t'(sd1.a[i]);
      sb[i]   = op_t'(b1[i]);
      addv[i] = sa[i] + sb[i];
      subv[i] = sa[i] - sb[i];
      negv[i] = -sa[i];
    end
    ss = op_t'(sd1.s);
    wt = ONE_OP - ss;
    sd2_next = sd1;
    for (int j = 0; j < 6; j++) begin
      opx_next[j] = '0;
      opy_next[j] = '0;
    end
    unique case (sd1.kind)
      KIND_ADD: begin
        for (int i = 0; i < 3; i++) begin
          sd2_next.r[i] = sat33(addv[i]);
          sd2_next.sat  = sd2_next.sat | ovf33(addv[i]);
        end
      end
      KIND_SUB: begin
        for (int i = 0; i < 3; i++) begin
          sd2_next.r[i] = sat33(subv[i]);
          sd2_next.sat  = sd2_next.sat | ovf33(subv[i]);
        end
      end
      KIND_NEG: begin
        for (int i = 0; i < 3; i++) begin
          sd2_next.r[i] = sat33(negv[i]);
          sd2_next.sat  = sd2_next.sat | ovf33(negv[i]);
        end
      end
      KIND_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          opx_next[i] = sa[i];
          opy_next[i] = ss;
        end
      end
      KIND_DOT: begin
        for (int i = 0; i < 3; i++) begin
          opx_next[i] = sa[i];
          opy_next[i] = sb[i];
        end
      end
      KIND_CROSS: begin
        opx_next[0] = sa[1];
        opy_next[0] = sb[2];
        opx_next[3] = sa[2];
        opy_next[3] = sb[1];
        opx_next[1] = sa[2];
        opy_next[1] = sb[0];
        opx_next[4] = sa[0];
        opy_next[4] = sb[2];
        opx_next[2] = sa[0];
        opy_next[2] = sb[1];
        opx_next[5] = sa[1];
        opy_next[5] = sb[0];
      end
      KIND_LEN, KIND_NORM: begin
        for (int i = 0; i < 3; i++) begin
          opx_next[i] = sa[i];
          opy_next[i] = sa[i];
        end
      end
      KIND_DIST: begin
        for (int i = 0; i < 3; i++) begin
          opx_next[i] = subv[i];
          opy_next[i] = subv[i];
        end
      end
      KIND_MIX: begin
        for (int i = 0; i < 3; i++) begin
          opx_next[i]     = wt;
          opy_next[i]     = sa[i];
          opx_next[i + 3] = ss;
          opy_next[i + 3] = sb[i];
        end
      end
      default: begin
      end
    endcase
  end

  // Stage 4: exact sums of products per lane.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_next[i] = sum_t'(prod[i]);
    end
    unique case (sd3.kind)
      KIND_DOT, KIND_LEN, KIND_DIST, KIND_NORM: begin
        sum_next[0] = sum_t'(prod[0]) + sum_t'(prod[1]) + sum_t'(prod[2]);
      end
      KIND_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          sum_next[i] = sum_t'(prod[i]) - sum_t'(prod[i + 3]);
        end
      end
      KIND_MIX: begin
        for (int i = 0; i < 3; i++) begin
          sum_next[i] = sum_t'(prod[i]) + sum_t'(prod[i + 3]);
        end
      end
      default: begin
      end
    endcase
  end

  // Stage 5: round half up, saturate, and clamp the radicand to 64 bits.
  always_comb begin
    sd5_next = sd4;
    for (int i = 0; i < 3; i++) begin
      rnd[i]      = (sum[i] + HALF_SUM) >>> FRAC_BITS;
      lane_ovf[i] = (rnd[i] > SUM_MAX) || (rnd[i] < SUM_MIN);
      if (lane_ovf[i]) begin
        lane_val[i] = rnd[i][SUM_W-1] ? Q_MIN : Q_MAX;
      end else begin
        lane_val[i] = rnd[i][31:0];
      end
    end
    unique case (sd4.kind)
      KIND_SCALE, KIND_CROSS, KIND_MIX: begin
        for (int i = 0; i < 3; i++) begin
          sd5_next.r[i] = lane_val[i];
        end
        sd5_next.sat = sd4.sat | (|lane_ovf);
      end
      KIND_DOT: begin
        sd5_next.sc  = lane_val[0];
        sd5_next.sat = sd4.sat | lane_ovf[0];
      end
      default: begin
      end
    endcase
    if (sum[0][SUM_W-1:RAD_W] != '0) begin
      rad_next = '1;
    end else begin
      rad_next = sum[0][RAD_W-1:0];
    end
  end

endmodule

// File: rtl/core/v3a_sqrt.sv
module v3a_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  v3a_pkg::side_t             in_side,
  input  logic [v3a_pkg::RAD_W-1:0]  rad,
  output logic                       out_valid,
  output v3a_pkg::side_t             out_side,
  output logic [v3a_pkg::ROOT_W-1:0] root
);
  import v3a_pkg::*;

  localparam int unsigned LAST = ROOT_STEPS - 1;

  logic             vld [ROOT_STEPS];
  side_t            sd  [ROOT_STEPS];
  logic [RAD_W-1:0] rem [ROOT_STEPS];
  logic [RAD_W-1:0] res [ROOT_STEPS];

  // One result bit per stage, most significant first.
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam int unsigned SH = 2 * (ROOT_STEPS - 1 - k);
    localparam logic [RAD_W-1:0] BIT_W = RAD_W'(1) << SH;

    logic             v_in;
    side_t            s_in;
    logic [RAD_W-1:0] n_in;
    logic [RAD_W-1:0] r_in;
    logic [RAD_W-1:0] trial;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign s_in = in_side;
      assign n_in = rad;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = vld[k-1];
      assign s_in = sd[k-1];
      assign n_in = rem[k-1];
      assign r_in = res[k-1];
    end

    assign trial = r_in + BIT_W;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[k] <= s_in;
        if (n_in >= trial) begin
          rem[k] <= n_in - trial;
          res[k] <= (r_in >> 1) + BIT_W;
        end else begin
          rem[k] <= n_in;
          res[k] <= r_in >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[LAST];
    end
  end

  // Round to nearest: step up when the remainder exceeds the truncated root.
  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= sd[LAST];
      if (rem[LAST] > res[LAST]) begin
        root <= ROOT_W'(res[LAST]) + ROOT_W'(1);
      end else begin
        root <= ROOT_W'(res[LAST]);
      end
    end
  end

endmodule

// File: rtl/core/v3a_div.sv
module v3a_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  v3a_pkg::side_t             in_side,
  input  logic [v3a_pkg::ROOT_W-1:0] root,
  output logic                       out_valid,
  output v3a_pkg::res_t              out_res
);
  import v3a_pkg::*;

  typedef logic [DIV_W-1:0] dv_t;

  typedef struct packed {
    side_t                     side;
    dv_t                       d;
    logic [2:0]                neg;
    logic [2:0]                ovf;
    logic [2:0][NUM_W-1:0]     num;
    dv_t [2:0]                 rem;
    logic [2:0][QUO_BITS-1:0]  quo;
  } dst_t;

  localparam int unsigned LAST = QUO_BITS - 1;
  localparam logic [QUO_BITS-1:0] LIM_POS = QUO_BITS'(32'h7FFF_FFFF);
  localparam logic [QUO_BITS-1:0] LIM_NEG = QUO_BITS'(32'h8000_0000);

  logic p1_v, p2_v;
  dst_t p1, p2, p1_next, p2_next;
  logic signed [32:0] s_ext;
  logic signed [32:0] a_ext [3];
  logic signed [32:0] a_abs [3];
  logic signed [32:0] s_abs;
  logic [31:0] mag_a [3];

  logic vld [QUO_BITS];
  dst_t stg [QUO_BITS];

  dst_t fin;
  res_t res_next;
  logic [QUO_BITS-1:0] q [3];
  logic [2:0] big;
  logic sat, err;

  // Prepare divisor, signs and rounded numerators |a| * 2^F + d / 2.
  always_comb begin
    p1_next      = '0;
    p1_next.side = in_side;
    s_ext        = {in_side.s[31], in_side.s};
    s_abs        = s_ext[32] ? -s_ext : s_ext;
    for (int i = 0; i < 3; i++) begin
      a_ext[i] = {in_side.a[i][31], in_side.a[i]};
      a_abs[i] = a_ext[i][32] ? -a_ext[i] : a_ext[i];
      mag_a[i] = a_abs[i][31:0];
    end
    unique case (in_side.kind)
      KIND_DIV: begin
        p1_next.d = dv_t'(s_abs);
        for (int i = 0; i < 3; i++) begin
          p1_next.neg[i] = in_side.a[i][31] ^ in_side.s[31];
        end
      end
      KIND_NORM: begin
        p1_next.d        = dv_t'(root);
        p1_next.side.err = (root == '0);
        for (int i = 0; i < 3; i++) begin
          p1_next.neg[i] = in_side.a[i][31];
        end
      end
      KIND_LEN, KIND_DIST: begin
        if (root[ROOT_W-1:31] != '0) begin
          p1_next.side.sc  = Q_MAX;
          p1_next.side.sat = 1'b1;
        end else begin
          p1_next.side.sc = root[31:0];
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      p1_next.num[i] = (NUM_W'(mag_a[i]) << FRAC_BITS) + NUM_W'(p1_next.d >> 1);
    end
  end

  // Top numerator bits above the quotient window; a quotient that needs them overflows.
  always_comb begin
    p2_next = p1;
    for (int i = 0; i < 3; i++) begin
      p2_next.rem[i] = dv_t'(p1.num[i][NUM_W-1:QUO_BITS]);
      p2_next.ovf[i] = dv_t'(p1.num[i][NUM_W-1:QUO_BITS]) >= p1.d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else if (en) begin
      p1_v <= in_valid;
      p2_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= p1_next;
      p2 <= p2_next;
    end
  end

  // Restoring division, one quotient bit per stage on all three lanes.
  for (genvar j = 0; j < QUO_BITS; j++) begin : g_step
    localparam int unsigned NB = QUO_BITS - 1 - j;

    logic             v_in;
    dst_t             s_in;
    dst_t             s_out;
    logic [DIV_W:0]   t [3];

    if (j == 0) begin : g_first
      assign v_in = p2_v;
      assign s_in = p2;
    end else begin : g_next
      assign v_in = vld[j-1];
      assign s_in = stg[j-1];
    end

    always_comb begin
      s_out = s_in;
      for (int i = 0; i < 3; i++) begin
        t[i] = {s_in.rem[i], s_in.num[i][NB]};
        if (t[i] >= {1'b0, s_in.d}) begin
          s_out.rem[i] = dv_t'(t[i] - {1'b0, s_in.d});
          s_out.quo[i] = {s_in.quo[i][QUO_BITS-2:0], 1'b1};
        end else begin
          s_out.rem[i] = t[i][DIV_W-1:0];
          s_out.quo[i] = {s_in.quo[i][QUO_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[j] <= s_out;
      end
    end
  end

  // Apply signs, saturate quotients and form the status code.
  always_comb begin
    fin        = stg[LAST];
    res_next.r  = fin.side.r;
    res_next.sc = fin.side.sc;
    sat        = fin.side.sat;
    err        = fin.side.err;
    for (int i = 0; i < 3; i++) begin
      q[i]   = fin.quo[i];
      big[i] = fin.ovf[i] || (fin.neg[i] ? (q[i] > LIM_NEG) : (q[i] > LIM_POS));
    end
    if ((fin.side.kind == KIND_DIV || fin.side.kind == KIND_NORM) && !err) begin
      for (int i = 0; i < 3; i++) begin
        if (big[i]) begin
          res_next.r[i] = fin.neg[i] ? Q_MIN : Q_MAX;
        end else if (fin.neg[i]) begin
          res_next.r[i] = 32'd0 - q[i][31:0];
        end else begin
          res_next.r[i] = q[i][31:0];
        end
      end
      sat = sat | (|big);
    end
    if (err) begin
      res_next.status = ST_ERR;
    end else if (sat) begin
      res_next.status = ST_SAT;
    end else begin
      res_next.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res <= res_next;
    end
  end

endmodule

// File: rtl/core/vector3_alu.sv
// Three-component vector arithmetic unit on signed Q16.16 values.
// Input channel: in_valid/in_ready carry one transaction per operation: kind, vectors
// a and b, and scalar_in. Output channel: out_valid/out_ready carry one transaction
// per input transaction, in order: vector r, scalar_out and status.
// Pipeline: 74 register stages from the input register to the output register.
// Throughput: one transaction per cycle while the receiver does not stall the output.
// Every stage does a fixed slice of work: operand selection, up to two 33x33
// multiplies per lane, sums, rounding, a 32-stage square root (one result bit per
// stage) and a 33-stage three-lane divider (one quotient bit per stage).
// Reset (rst, synchronous) clears every valid bit; the pipeline is empty afterward
// and no result is offered until new input transactions arrive.
// Receiver stall: while out_valid is high and out_ready is low the whole pipeline
// holds, and in_ready drops; nothing in flight is lost or repeated. The input is
// accepted whenever the output register is empty or is being taken this cycle.
module vector3_alu (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  v3a_pkg::kind_t kind,
  input  v3a_pkg::q_t    a_x,
  input  v3a_pkg::q_t    a_y,
  input  v3a_pkg::q_t    a_z,
  input  v3a_pkg::q_t    b_x,
  input  v3a_pkg::q_t    b_y,
  input  v3a_pkg::q_t    b_z,
  input  v3a_pkg::q_t    scalar_in,
  output logic           out_valid,
  input  logic           out_ready,
  output v3a_pkg::q_t    r_x,
  output v3a_pkg::q_t    r_y,
  output v3a_pkg::q_t    r_z,
  output v3a_pkg::q_t    scalar_out,
  output logic [1:0]     status
);
  import v3a_pkg::*;

  // One enable moves every stage together: the pipeline advances unless a finished
  // result is sitting in the output register and the receiver is not taking it.
  logic en;

  logic                front_valid;
  side_t               front_side;
  logic [RAD_W-1:0]    front_rad;
  logic                root_valid;
  side_t               root_side;
  logic [ROOT_W-1:0]   root_val;
  res_t                res;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Operand selection, multipliers, sums of products and rounding.
  v3a_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .kind      (kind),
    .a_x       (a_x),
    .a_y       (a_y),
    .a_z       (a_z),
    .b_x       (b_x),
    .b_y       (b_y),
    .b_z       (b_z),
    .scalar_in (scalar_in),
    .out_valid (front_valid),
    .out_side  (front_side),
    .rad       (front_rad)
  );

  // Rounded square root of the sum of squares for length, distance and normalize.
  v3a_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_side   (front_side),
    .rad       (front_rad),
    .out_valid (root_valid),
    .out_side  (root_side),
    .root      (root_val)
  );

  // Rounded division for divide and normalize; the last stage is the output register.
  v3a_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (root_valid),
    .in_side   (root_side),
    .root      (root_val),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign r_x        = res.r[0];
  assign r_y        = res.r[1];
  assign r_z        = res.r[2];
  assign scalar_out = res.sc;
  assign status     = res.status;

  // Reset must flush the pipeline so that no stale result reaches the output.
  a_reset_flush: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // The status code is never the unused value.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_SAT || status == ST_ERR))
    else $error("unused status code");

  // A division by zero or a zero-length normalize returns all zeros.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_ERR) |->
      (r_x == '0 && r_y == '0 && r_z == '0 && scalar_out == '0))
    else $error("error result is not zero");

endmodule
